// File: rtl/byte_ring_fifo_threshold_macros.svh
// Assertion helpers used by the RTL datapath. Every check is clocked on aclk
// and held off while aresetn is low.
`ifndef BYTE_RING_FIFO_THRESHOLD_MACROS_SVH
`define BYTE_RING_FIFO_THRESHOLD_MACROS_SVH

// Same-cycle implication.
`define BRFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("brft same-cycle check failed");

// Next-cycle implication.
`define BRFT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("brft next-cycle check failed");

`endif

// File: rtl/brft_pkg.sv
package brft_pkg;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int THR_W  = 9;
    localparam int FILL_W = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ENABLE   = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              ok;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
        logic              is_full;
        logic              threshold_hit;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// File: rtl/brft_ctrl.sv
module brft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brft_pkg::status_t status,
    output brft_pkg::ctrl_t   ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Outputs of the sequencer
    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        ctrl.capture = s_valid && (state_reg == S_IDLE);
        ctrl.commit  = (state_reg == S_EXEC) && status.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/brft_datapath.sv
`include "byte_ring_fifo_threshold_macros.svh"

module brft_datapath #(
    parameter int DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  brft_pkg::in_t                        s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output brft_pkg::out_t                       m_data,
    input  logic                                 cfg_we,
    input  logic [brft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  brft_pkg::ctrl_t                      ctrl,
    output brft_pkg::status_t                    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > brft_pkg::THR_W) ? CNT_W : brft_pkg::THR_W;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    // Byte store
    logic [brft_pkg::BYTE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             has_data_reg, has_data_next;
    logic             has_room_reg, has_room_next;

    logic [brft_pkg::THR_W-1:0] thr_reg;
    logic                       notify_reg;

    // Captured command and the byte read at the read pointer
    logic [brft_pkg::CMD_W-1:0]  cmd_reg;
    logic [brft_pkg::BYTE_W-1:0] din_reg;
    logic [brft_pkg::BYTE_W-1:0] rd_data_reg;

    logic           m_valid_reg;
    brft_pkg::out_t out_reg, out_next;

    logic             ok;
    logic             wr_en;
    logic [CNT_W-1:0] cnt;
    logic [CMP_W-1:0] cnt_ext;
    logic             ptr_eq;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= '0;
            notify_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                brft_pkg::REG_LEVEL_THRESHOLD: thr_reg    <= cfg_wdata[brft_pkg::THR_W-1:0];
                brft_pkg::REG_NOTIFY_ENABLE:   notify_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Command capture and store read on transfer in
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg     <= s_data.cmd;
            din_reg     <= s_data.data_in;
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Store write on a committed push
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= din_reg;
        end
    end

    // Command execution
    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        has_data_next = has_data_reg;
        has_room_next = has_room_reg;
        ok            = 1'b0;
        wr_en         = 1'b0;
        out_next      = '0;
        case (cmd_reg)
            brft_pkg::CMD_PUSH: begin
                if (has_room_reg) begin
                    wr_en         = ctrl.commit;
                    wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    has_room_next = (wr_ptr_next != rd_ptr_reg);
                    has_data_next = 1'b1;
                    ok            = 1'b1;
                end
            end
            brft_pkg::CMD_POP: begin
                if (has_data_reg) begin
                    out_next.data_out = rd_data_reg;
                    rd_ptr_next   = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    has_data_next = (rd_ptr_next != wr_ptr_reg);
                    has_room_next = 1'b1;
                    ok            = 1'b1;
                end
            end
            brft_pkg::CMD_RECALL: begin
                if (has_room_reg) begin
                    rd_ptr_next   = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - 1'b1;
                    has_room_next = (rd_ptr_next != wr_ptr_reg);
                    has_data_next = 1'b1;
                    ok            = 1'b1;
                end
            end
            default: begin
                rd_ptr_next   = wr_ptr_reg;
                has_data_next = 1'b0;
                has_room_next = 1'b1;
                ok            = 1'b1;
            end
        endcase

        // Fill level after the command; wraps by DEPTH when write is behind read
        ptr_eq = (rd_ptr_next == wr_ptr_next);
        if (ptr_eq) begin
            cnt = has_data_next ? CNT_DEPTH : '0;
        end else if (wr_ptr_next > rd_ptr_next) begin
            cnt = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        end else begin
            cnt = CNT_DEPTH - {1'b0, rd_ptr_next} + {1'b0, wr_ptr_next};
        end
        cnt_ext = CMP_W'(cnt);

        out_next.ok            = ok;
        out_next.fill_count    = cnt_ext[brft_pkg::FILL_W-1:0];
        out_next.is_empty      = ptr_eq && !has_data_next;
        out_next.is_full       = ptr_eq && has_data_next;
        out_next.threshold_hit = (cmd_reg == brft_pkg::CMD_PUSH) && ok && notify_reg &&
                                 (cnt_ext >= CMP_W'(thr_reg));
    end

    // Pointer and flag state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            has_data_reg <= 1'b0;
            has_room_reg <= 1'b1;
        end else if (ctrl.commit) begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            has_data_reg <= has_data_next;
            has_room_reg <= has_room_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            out_reg <= out_next;
        end
    end

    // Checks
    `BRFT_ASSERT_IMP(a_flags_live, 1'b1, has_data_reg || has_room_reg)
    `BRFT_ASSERT_IMP(a_partial_flags, rd_ptr_reg != wr_ptr_reg, has_data_reg && has_room_reg)
    `BRFT_ASSERT_IMP(a_commit_free, ctrl.commit, !m_valid_reg || m_ready)
    `BRFT_ASSERT_NXT(a_commit_shows, ctrl.commit, m_valid_reg)

endmodule

// File: rtl/byte_ring_fifo_threshold.sv
// Byte ring FIFO with fill-level notification for a UART receive path.
// Input channel s_valid/s_ready/s_data carries a command (push, pop,
// recall, flush) and a byte; every command yields exactly one result on
// m_valid/m_ready/m_data: popped byte, ok, fill count, empty, full and
// threshold hit. The user must write registers via cfg_we/cfg_index/cfg_wdata
// (index 0 level threshold, 1 notify enable) only while the block is idle;
// the block does not enforce this. A command is taken and its store read is
// registered; it executes once the output register is free, and the result
// is valid the cycle after that. A new command is not taken until the last
// has executed, since the registered store read precedes the pointer update.
// The result sits in an output register, so a new command is taken while
// the previous result waits. If the receiver stalls with a result still
// held, the next command waits in execution and s_ready stays low.
// Reset (aresetn low, synchronous) empties the FIFO and clears the
// registers; store contents are left as they are and are not popped until
// written, except after a recall over never-written bytes.
module byte_ring_fifo_threshold #(
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  brft_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output brft_pkg::out_t                   m_data,
    input  logic                             cfg_we,
    input  logic [brft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brft_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    brft_pkg::ctrl_t   ctrl;
    brft_pkg::status_t status;

    brft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    brft_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

// File: test/tb_byte_ring_fifo_threshold.sv
module tb_byte_ring_fifo_threshold;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int STALL_LIMIT = 1000;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    brft_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    brft_pkg::out_t                  m_data;
    logic                            cfg_we;
    logic [brft_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [brft_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Shadow copy of the FIFO state and registers
    bit [7:0]  ring_mem [DEPTH];
    bit        ring_written [DEPTH];
    bit [7:0]  rd_pos;
    bit [7:0]  wr_pos;
    bit        holds_data;
    bit        has_space;
    bit [8:0]  thr_cfg;
    bit        notify_cfg;

    brft_pkg::out_t fifo_resp_q[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    byte_ring_fifo_threshold #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bytes held; equal pointers mean either empty or full
    function automatic bit [8:0] fifo_level();
        if (rd_pos == wr_pos)
            return holds_data ? 9'(DEPTH) : 9'd0;
        return {1'b0, 8'(wr_pos - rd_pos)};
    endfunction

    // Apply one command to the shadow state and return its result
    function automatic brft_pkg::out_t fifo_apply(input brft_pkg::in_t item);
        brft_pkg::out_t r;
        r = '0;
        case (item.cmd)
            brft_pkg::CMD_PUSH: begin
                if (has_space) begin
                    ring_mem[wr_pos] = item.data_in;
                    ring_written[wr_pos] = 1'b1;
                    wr_pos++;
                    if (wr_pos == rd_pos)
                        has_space = 1'b0;
                    holds_data = 1'b1;
                    r.ok = 1'b1;
                    if (notify_cfg && fifo_level() >= thr_cfg)
                        r.threshold_hit = 1'b1;
                end
            end
            brft_pkg::CMD_POP: begin
                if (holds_data) begin
                    r.data_out = ring_mem[rd_pos];
                    rd_pos++;
                    if (rd_pos == wr_pos)
                        holds_data = 1'b0;
                    has_space = 1'b1;
                    r.ok = 1'b1;
                end
            end
            brft_pkg::CMD_RECALL: begin
                if (has_space) begin
                    rd_pos--;
                    if (rd_pos == wr_pos)
                        has_space = 1'b0;
                    holds_data = 1'b1;
                    r.ok = 1'b1;
                end
            end
            default: begin
                rd_pos = wr_pos;
                holds_data = 1'b0;
                has_space = 1'b1;
                r.ok = 1'b1;
            end
        endcase
        r.fill_count = fifo_level();
        r.is_empty   = (rd_pos == wr_pos) && !holds_data;
        r.is_full    = (rd_pos == wr_pos) && holds_data;
        return r;
    endfunction

    function automatic brft_pkg::in_t make_cmd(input logic [brft_pkg::CMD_W-1:0] cmd,
                                               input logic [7:0] data);
        brft_pkg::in_t item;
        item.cmd = cmd;
        item.data_in = data;
        return item;
    endfunction

    // Weighted random command; flush takes the remaining share
    function automatic brft_pkg::in_t random_cmd(input int push_w, input int pop_w,
                                                 input int recall_w);
        brft_pkg::in_t item;
        int  roll;
        roll = $urandom_range(0, 99);
        item.data_in = 8'($urandom_range(0, 255));
        if (roll < push_w)
            item.cmd = brft_pkg::CMD_PUSH;
        else if (roll < push_w + pop_w)
            item.cmd = brft_pkg::CMD_POP;
        else if (roll < push_w + pop_w + recall_w)
            item.cmd = brft_pkg::CMD_RECALL;
        else
            item.cmd = brft_pkg::CMD_FLUSH;
        // never pop a slot that a recall exposed before it was written
        if (item.cmd == brft_pkg::CMD_POP && holds_data && !ring_written[rd_pos])
            item.cmd = has_space ? brft_pkg::CMD_PUSH : brft_pkg::CMD_FLUSH;
        return item;
    endfunction

    // One command transfer; called and returns at a falling edge, valid left high
    task automatic send_cmd(input brft_pkg::in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        fifo_resp_q.push_back(fifo_apply(item));
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (fifo_resp_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [brft_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brft_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == brft_pkg::REG_LEVEL_THRESHOLD)
            thr_cfg = val;
        else if (idx == brft_pkg::REG_NOTIFY_ENABLE)
            notify_cfg = val[0];
        @(negedge aclk);
    endtask

    // Empty pops, recall wrap from slot 0, push/pop extremes and re-read after recall
    task automatic test_basic_ops();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_write(brft_pkg::REG_LEVEL_THRESHOLD, 9'd2);
        cfg_write(brft_pkg::REG_NOTIFY_ENABLE, 9'd1);
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_RECALL, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_FLUSH, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h5A));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'hA5));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_RECALL, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'hFF));
        send_cmd(make_cmd(brft_pkg::CMD_RECALL, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_FLUSH, 8'h00));
        wait_idle();
    endtask

    // Notification off, threshold of zero, and a threshold just reached
    task automatic test_threshold();
        cfg_write(brft_pkg::REG_LEVEL_THRESHOLD, 9'd0);
        cfg_write(brft_pkg::REG_NOTIFY_ENABLE, 9'd0);
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h11));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h22));
        wait_idle();
        cfg_write(brft_pkg::REG_NOTIFY_ENABLE, 9'd1);
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h33));
        wait_idle();
        cfg_write(brft_pkg::REG_LEVEL_THRESHOLD, 9'd5);
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h44));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h55));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h66));
        send_cmd(make_cmd(brft_pkg::CMD_FLUSH, 8'h00));
        wait_idle();
    endtask

    // Fill to full with the top threshold, then every command on a full FIFO
    task automatic test_full();
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        cfg_write(brft_pkg::REG_LEVEL_THRESHOLD, 9'(DEPTH));
        cfg_write(brft_pkg::REG_NOTIFY_ENABLE, 9'd1);
        while (has_space)
            send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'($urandom_range(0, 255))));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'hC3));
        send_cmd(make_cmd(brft_pkg::CMD_RECALL, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_RECALL, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_PUSH, 8'h3C));
        send_cmd(make_cmd(brft_pkg::CMD_FLUSH, 8'h00));
        send_cmd(make_cmd(brft_pkg::CMD_POP, 8'h00));
        wait_idle();
    endtask

    // Climb toward full with random traffic, then drain with flushes mixed in
    task automatic test_random(input int idle_pct, input int stall_pct,
                               input logic [8:0] thr, input bit notify, input bit pause_midway);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        cfg_write(brft_pkg::REG_LEVEL_THRESHOLD, thr);
        cfg_write(brft_pkg::REG_NOTIFY_ENABLE, {8'd0, notify});
        for (int i = 0; i < 300; i++) begin
            if (pause_midway && i == 150)
                wait_idle();
            send_cmd(random_cmd(85, 10, 5));
        end
        for (int i = 0; i < 50; i++)
            send_cmd(random_cmd(25, 55, 8));
        wait_idle();
    endtask

    // Receiver ready pattern
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker against the oldest pending expectation
    always @(posedge aclk) begin
        brft_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (fifo_resp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: data=%h ok=%b fill=%0d",
                             m_data.data_out, m_data.ok, m_data.fill_count);
            end else begin
                want = fifo_resp_q.pop_front();
                if (m_data.data_out !== want.data_out || m_data.ok !== want.ok ||
                    m_data.fill_count !== want.fill_count || m_data.is_empty !== want.is_empty ||
                    m_data.is_full !== want.is_full ||
                    m_data.threshold_hit !== want.threshold_hit) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp data=%h ok=%b fill=%0d empty=%b full=%b hit=%b",
                                  " | got data=%h ok=%b fill=%0d empty=%b full=%b hit=%b"},
                                 want.data_out, want.ok, want.fill_count, want.is_empty,
                                 want.is_full, want.threshold_hit, m_data.data_out, m_data.ok,
                                 m_data.fill_count, m_data.is_empty, m_data.is_full,
                                 m_data.threshold_hit);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        rd_pos         = '0;
        wr_pos         = '0;
        holds_data     = 1'b0;
        has_space      = 1'b1;
        thr_cfg        = '0;
        notify_cfg     = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_ops();
        test_threshold();
        test_full();
        test_random(0, 0, 9'd0, 1'b1, 1'b0);
        test_random(87, 0, 9'(DEPTH), 1'b1, 1'b1);
        test_random(0, 87, 9'($urandom_range(1, 255)), 1'b0, 1'b0);
        test_random(32, 32, 9'($urandom_range(0, 256)), 1'b1, 1'b0);

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && fifo_resp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/brft_pkg.sv
rtl/brft_ctrl.sv
rtl/brft_datapath.sv
rtl/byte_ring_fifo_threshold.sv
test/tb_byte_ring_fifo_threshold.sv
